>>> rtl/lfst_pkg.sv
// Shared types, codes and sizes for the lowest free slot table.
`timescale 1ns / 1ps

package lfst_pkg;

	// Table geometry
	localparam int SLOTS    = 64;
	localparam int IDX_W    = $clog2(SLOTS);
	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int HANDLE_W = 32;

	// Vacancy search: slots are scanned in groups
	localparam int GRP_W  = 8;
	localparam int GRPS   = SLOTS / GRP_W;
	localparam int GPOS_W = $clog2(GRP_W);

	// Operation codes
	localparam logic [2:0] KIND_ADD_LOWEST = 3'd0;
	localparam logic [2:0] KIND_ADD_AT     = 3'd1;
	localparam logic [2:0] KIND_REMOVE     = 3'd2;
	localparam logic [2:0] KIND_LOOKUP     = 3'd3;
	localparam logic [2:0] KIND_CLEAR      = 3'd4;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  slot_index;
		logic [31:0] entry_data;
	} req_t;

	typedef struct packed {
		logic [5:0]  result_index;
		logic [31:0] result_data;
		logic        occupied;
		logic [1:0]  status;
		logic [6:0]  occupied_count;
		logic [6:0]  lowest_vacant;
	} rsp_t;

endpackage

>>> rtl/lfst_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module lfst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/lfst_vac_scan.sv
// Two-step search for the lowest vacant slot over the valid bits.
`timescale 1ns / 1ps

module lfst_vac_scan (
	input  logic                                 clk,
	input  logic [lfst_pkg::SLOTS-1:0]           slot_valid,
	output logic [lfst_pkg::CNT_W-1:0]           first_vacant
);

	import lfst_pkg::*;

	logic [GRPS-1:0]   grp_full;
	logic [GPOS_W-1:0] grp_pos [GRPS];
	logic [GRPS-1:0]   grp_full_s1;
	logic [GPOS_W-1:0] grp_pos_s1 [GRPS];

	// first step: lowest clear bit inside each group
	always_comb begin
		for (int g = 0; g < GRPS; g++) begin
			grp_full[g] = &slot_valid[g*GRP_W +: GRP_W];
			grp_pos[g]  = '0;
			for (int b = GRP_W - 1; b >= 0; b--) begin
				if (!slot_valid[g*GRP_W + b]) begin
					grp_pos[g] = GPOS_W'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_full_s1 <= grp_full;
		for (int g = 0; g < GRPS; g++) begin
			grp_pos_s1[g] <= grp_pos[g];
		end
	end

	// second step: lowest group that is not full; SLOTS when all are full
	always_comb begin
		first_vacant = CNT_W'(SLOTS);
		for (int g = GRPS - 1; g >= 0; g--) begin
			if (!grp_full_s1[g]) begin
				first_vacant = CNT_W'(g * GRP_W) + CNT_W'(grp_pos_s1[g]);
			end
		end
	end

endmodule

>>> rtl/lowest_free_slot_table.sv
// Top level of the lowest free slot table: control, valid bits, handle store.
`timescale 1ns / 1ps
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------
//  req     | in        | req_valid / req_ready | lfst_pkg::req_t
//  rsp     | out       | rsp_valid / rsp_ready | lfst_pkg::rsp_t
//
//  Each operation updates the valid bits, count and handle RAM in its accept
//  cycle, then the vacancy search needs one registered step (S_SCAN, S_DONE).
//  A new request is taken in S_DONE of the previous one, as its result loads.
//  Reset empties the table at once; handles need no clearing.
//  A result waiting in the output register lets one more request be taken;
//  the block then holds in its final step until the output is free.

module lowest_free_slot_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lfst_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lfst_pkg::rsp_t rsp
);

	import lfst_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]          state_q;
	logic [SLOTS-1:0]    valid_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    first_vacant_q;
	logic [CNT_W-1:0]    fv_next;
	logic [CNT_W-1:0]    fv_cur;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic                accept;
	logic                load_ok;
	logic                load;
	logic                in_range;
	logic [IDX_W-1:0]    tgt;

	// decoded operation
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic                set_en;
	logic                clr_en;
	logic                clr_all;
	logic                rd_en;
	logic [IDX_W-1:0]    r_index;
	logic [1:0]          r_status;
	logic                r_occ;

	logic [IDX_W-1:0]    op_index_q;
	logic [1:0]          op_status_q;
	logic                op_occ_q;
	logic [HANDLE_W-1:0] rd_data;

	assign load_ok   = !rsp_valid_q || rsp_ready;
	assign load      = (state_q == S_DONE) && load_ok;
	assign req_ready = (state_q == S_IDLE) || load;
	assign accept    = req_valid && req_ready;
	assign in_range  = (req.slot_index[7:IDX_W] == '0);
	assign tgt       = req.slot_index[IDX_W-1:0];
	// lowest vacant slot as seen by the request being taken
	assign fv_cur    = (state_q == S_DONE) ? fv_next : first_vacant_q;

	// operation decode
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = tgt;
		set_en   = 1'b0;
		clr_en   = 1'b0;
		clr_all  = 1'b0;
		rd_en    = 1'b0;
		r_index  = '0;
		r_status = ST_OK;
		r_occ    = 1'b0;
		case (req.kind)
			KIND_ADD_LOWEST: begin
				if (fv_cur == CNT_W'(SLOTS)) begin
					r_status = ST_FULL;
				end else begin
					wr_addr = fv_cur[IDX_W-1:0];
					r_index = fv_cur[IDX_W-1:0];
					wr_en   = 1'b1;
					set_en  = 1'b1;
				end
			end
			KIND_ADD_AT: begin
				r_index = tgt;
				if (in_range) begin
					wr_en  = 1'b1;
					set_en = 1'b1;
				end else begin
					r_status = ST_IGNORED;
				end
			end
			KIND_REMOVE: begin
				r_index = tgt;
				if (in_range && valid_q[tgt]) begin
					clr_en = 1'b1;
				end else begin
					r_status = ST_IGNORED;
				end
			end
			KIND_LOOKUP: begin
				r_index = tgt;
				rd_en   = 1'b1;
				if (in_range) begin
					r_occ = valid_q[tgt];
				end else begin
					r_status = ST_IGNORED;
				end
			end
			KIND_CLEAR: begin
				clr_all = 1'b1;
			end
			default: begin
				r_status = ST_IGNORED;
			end
		endcase
	end

	// handle store
	lfst_ram #(
		.WIDTH (HANDLE_W),
		.DEPTH (SLOTS)
	) u_handle_ram (
		.clk     (clk),
		.wr_en   (accept && wr_en),
		.wr_addr (wr_addr),
		.wr_data (req.entry_data),
		.rd_en   (accept && rd_en),
		.rd_addr (tgt),
		.rd_data (rd_data)
	);

	// vacancy search
	lfst_vac_scan u_vac_scan (
		.clk          (clk),
		.slot_valid   (valid_q),
		.first_vacant (fv_next)
	);

	// valid bits and occupied count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (clr_all) begin
				valid_q <= '0;
				count_q <= '0;
			end else if (set_en) begin
				valid_q[wr_addr] <= 1'b1;
				if (!valid_q[wr_addr]) begin
					count_q <= count_q + 1'b1;
				end
			end else if (clr_en) begin
				valid_q[tgt] <= 1'b0;
				count_q      <= count_q - 1'b1;
			end
		end
	end

	// per-operation result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			op_index_q  <= r_index;
			op_status_q <= r_status;
			op_occ_q    <= r_occ;
		end
	end

	// sequencer and lowest vacant slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			first_vacant_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load) begin
						first_vacant_q <= fv_next;
						state_q        <= accept ? S_SCAN : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q.result_index   <= 6'(op_index_q);
			rsp_q.result_data    <= op_occ_q ? 32'(rd_data) : '0;
			rsp_q.occupied       <= op_occ_q;
			rsp_q.status         <= op_status_q;
			rsp_q.occupied_count <= 7'(count_q);
			rsp_q.lowest_vacant  <= 7'(fv_next);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("occupied count above table size");

	a_accept_state: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (state_q == S_IDLE || state_q == S_DONE))
		else $error("request taken while an operation is in flight");

	a_full_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((first_vacant_q == CNT_W'(SLOTS)) == (count_q == CNT_W'(SLOTS))))
		else $error("full flag and count disagree");

	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |=> (state_q == S_DONE))
		else $error("search step not followed by completion");

endmodule

>>> tb/sv/tb_lowest_free_slot_table.sv
// Self-checking testbench for the lowest free slot table: directed rows, a fill past full, then random bursts.
`timescale 1ns / 1ps

module tb_lowest_free_slot_table;
	import lfst_pkg::*;

	// Stimulus mix for one random burst
	typedef enum logic [1:0] {
		BURST_FILL,
		BURST_DRAIN,
		BURST_MIXED
	} burst_t;

	// One directed row; want is only used when fixed is set
	typedef struct packed {
		req_t op;
		logic fixed;
		rsp_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// Shadow of the table contents
	logic                tbl_valid   [SLOTS];
	logic [HANDLE_W-1:0] tbl_handle  [SLOTS];
	logic                tbl_written [SLOTS];
	logic [CNT_W-1:0]    tbl_lowest;
	logic [CNT_W-1:0]    tbl_count;

	rsp_t     rsp_due[$];
	dir_row_t dir_rows[$];
	int       mismatches = 0;
	bit       steady = 1'b0;

	lowest_free_slot_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	// Write a handle, count a new occupant, rescan for the lowest vacancy
	function automatic void store_slot(logic [IDX_W-1:0] idx, logic [HANDLE_W-1:0] data);
		int i;
		if (!tbl_valid[idx]) begin
			tbl_count = tbl_count + 1'b1;
		end
		tbl_valid[idx]   = 1'b1;
		tbl_handle[idx]  = data;
		tbl_written[idx] = 1'b1;
		for (i = 0; i < SLOTS; i++) begin
			if (!tbl_valid[i]) break;
		end
		tbl_lowest = CNT_W'(i);
	endfunction

	// Apply one operation to the shadow table and return the result it gives
	function automatic rsp_t apply_table_op(req_t op);
		rsp_t             r;
		logic             in_range;
		logic [IDX_W-1:0] idx;
		r        = '0;
		in_range = (op.slot_index < SLOTS);
		idx      = op.slot_index[IDX_W-1:0];
		case (op.kind)
			KIND_ADD_LOWEST: begin
				if (tbl_lowest >= SLOTS) begin
					r.status = ST_FULL;
				end else begin
					r.result_index = tbl_lowest[IDX_W-1:0];
					store_slot(tbl_lowest[IDX_W-1:0], op.entry_data);
				end
			end
			KIND_ADD_AT: begin
				r.result_index = idx;
				if (!in_range) r.status = ST_IGNORED;
				else store_slot(idx, op.entry_data);
			end
			KIND_REMOVE: begin
				r.result_index = idx;
				if (!in_range || !tbl_valid[idx]) begin
					r.status = ST_IGNORED;
				end else begin
					tbl_valid[idx] = 1'b0;
					tbl_count      = tbl_count - 1'b1;
					if (tbl_lowest > idx) tbl_lowest = CNT_W'(idx);
				end
			end
			KIND_LOOKUP: begin
				r.result_index = idx;
				if (!in_range) begin
					r.status = ST_IGNORED;
				end else if (tbl_valid[idx]) begin
					r.occupied    = 1'b1;
					r.result_data = tbl_handle[idx];
				end
			end
			KIND_CLEAR: begin
				foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
				tbl_count  = '0;
				tbl_lowest = '0;
			end
			default: r.status = ST_IGNORED;
		endcase
		r.occupied_count = tbl_count;
		r.lowest_vacant  = tbl_lowest;
		return r;
	endfunction

	function automatic dir_row_t fixed_row(logic [2:0] k, logic [7:0] s, logic [31:0] d,
			logic [5:0] ri, logic [31:0] rd, logic oc, logic [1:0] st,
			logic [6:0] cnt, logic [6:0] vac);
		dir_row_t row;
		row.op    = '{kind: k, slot_index: s, entry_data: d};
		row.fixed = 1'b1;
		row.want  = '{result_index: ri, result_data: rd, occupied: oc, status: st,
			occupied_count: cnt, lowest_vacant: vac};
		return row;
	endfunction

	function automatic dir_row_t open_row(logic [2:0] k, logic [7:0] s, logic [31:0] d);
		dir_row_t row;
		row.op    = '{kind: k, slot_index: s, entry_data: d};
		row.fixed = 1'b0;
		row.want  = '0;
		return row;
	endfunction

	function automatic logic [31:0] draw_handle();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 32'h0000_0000;
		if (r == 1) return 32'hFFFF_FFFF;
		return $urandom();
	endfunction

	// Mostly in range, sometimes beyond the table
	function automatic logic [7:0] draw_index();
		if ($urandom_range(0, 9) == 0) return 8'($urandom_range(SLOTS, 255));
		return 8'($urandom_range(0, SLOTS - 1));
	endfunction

	// Scan from a random slot for one that is occupied (or, for lookups, ever written);
	// out of range when none qualifies
	function automatic logic [7:0] find_slot(bit any_written);
		int start;
		int k;
		int s;
		start = $urandom_range(0, SLOTS - 1);
		for (k = 0; k < SLOTS; k++) begin
			s = (start + k) % SLOTS;
			if (any_written ? tbl_written[s] : tbl_valid[s]) return 8'(s);
		end
		return 8'($urandom_range(SLOTS, 255));
	endfunction

	// Draw one random operation, shaped by the burst mix
	function automatic req_t pick_op(burst_t mode);
		req_t op;
		int   r;
		int   c_low;
		int   c_at;
		int   c_rem;
		int   c_look;
		r          = $urandom_range(0, 99);
		op.kind    = KIND_ADD_LOWEST;
		op.slot_index = 8'($urandom_range(0, 255));
		op.entry_data = draw_handle();
		case (mode)
			BURST_FILL:  begin c_low = 55; c_at = 75; c_rem = 82; c_look = 97; end
			BURST_DRAIN: begin c_low = 10; c_at = 20; c_rem = 70; c_look = 92; end
			default:     begin c_low = 25; c_at = 45; c_rem = 70; c_look = 92; end
		endcase
		if (r < c_low) begin
			op.kind = KIND_ADD_LOWEST;
		end else if (r < c_at) begin
			op.kind       = KIND_ADD_AT;
			op.slot_index = draw_index();
		end else if (r < c_rem) begin
			op.kind       = KIND_REMOVE;
			op.slot_index = ($urandom_range(0, 99) < 15) ? draw_index() : find_slot(1'b0);
		end else if (r < c_look) begin
			op.kind       = KIND_LOOKUP;
			op.slot_index = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(SLOTS, 255))
				: find_slot(1'b1);
		end else if (mode != BURST_FILL && $urandom_range(0, 1) == 0) begin
			op.kind = KIND_CLEAR;
		end else begin
			op.kind = 3'($urandom_range(5, 7));
		end
		return op;
	endfunction

	// Offer one request, and on transfer queue the result it must give
	task automatic issue(req_t op, logic fixed, rsp_t want);
		int   gap;
		rsp_t pred;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= op;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		pred = apply_table_op(op);
		rsp_due.push_back(fixed ? want : pred);
	endtask

	// Hold off the sender until every queued result has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (rsp_due.size() != 0) @(posedge clk);
	endtask

	task automatic check_result(rsp_t got);
		rsp_t exp;
		if (rsp_due.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			mismatches++;
		end else begin
			exp = rsp_due.pop_front();
			if (got.result_index !== exp.result_index) begin
				$display("%0t: result_index expected %0d got %0d", $time,
					exp.result_index, got.result_index);
				mismatches++;
			end
			if (got.result_data !== exp.result_data) begin
				$display("%0t: result_data expected %h got %h", $time,
					exp.result_data, got.result_data);
				mismatches++;
			end
			if (got.occupied !== exp.occupied) begin
				$display("%0t: occupied expected %0b got %0b", $time,
					exp.occupied, got.occupied);
				mismatches++;
			end
			if (got.status !== exp.status) begin
				$display("%0t: status expected %0d got %0d", $time, exp.status, got.status);
				mismatches++;
			end
			if (got.occupied_count !== exp.occupied_count) begin
				$display("%0t: occupied_count expected %0d got %0d", $time,
					exp.occupied_count, got.occupied_count);
				mismatches++;
			end
			if (got.lowest_vacant !== exp.lowest_vacant) begin
				$display("%0t: lowest_vacant expected %0d got %0d", $time,
					exp.lowest_vacant, got.lowest_vacant);
				mismatches++;
			end
		end
	endtask

	// Result side: random stalls, check on every transfer
	initial begin
		int gap;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = steady ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			check_result(rsp);
		end
	end

	// Request side and end of run
	initial begin
		int     sent;
		int     len;
		burst_t mode;
		req_valid = 1'b0;
		req       = '0;
		arst_n    = 1'b0;
		foreach (tbl_valid[i]) begin
			tbl_valid[i]   = 1'b0;
			tbl_handle[i]  = '0;
			tbl_written[i] = 1'b0;
		end
		tbl_lowest = '0;
		tbl_count  = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: empty table, edge slots, out-of-range indexes, odd kinds, clear
		dir_rows.push_back(fixed_row(KIND_ADD_LOWEST, 8'd0, 32'h0000_0000,
			6'd0, 32'h0, 1'b0, ST_OK, 7'd1, 7'd1));
		dir_rows.push_back(fixed_row(KIND_LOOKUP, 8'd0, 32'h0,
			6'd0, 32'h0, 1'b1, ST_OK, 7'd1, 7'd1));
		dir_rows.push_back(fixed_row(KIND_ADD_AT, 8'd63, 32'hFFFF_FFFF,
			6'd63, 32'h0, 1'b0, ST_OK, 7'd2, 7'd1));
		dir_rows.push_back(fixed_row(KIND_LOOKUP, 8'd63, 32'h0,
			6'd63, 32'hFFFF_FFFF, 1'b1, ST_OK, 7'd2, 7'd1));
		dir_rows.push_back(fixed_row(KIND_ADD_AT, 8'd255, 32'hA5A5_A5A5,
			6'd63, 32'h0, 1'b0, ST_IGNORED, 7'd2, 7'd1));
		dir_rows.push_back(fixed_row(KIND_ADD_AT, 8'd64, 32'h5A5A_5A5A,
			6'd0, 32'h0, 1'b0, ST_IGNORED, 7'd2, 7'd1));
		dir_rows.push_back(fixed_row(KIND_REMOVE, 8'd5, 32'h0,
			6'd5, 32'h0, 1'b0, ST_IGNORED, 7'd2, 7'd1));
		dir_rows.push_back(fixed_row(KIND_REMOVE, 8'd200, 32'h0,
			6'd8, 32'h0, 1'b0, ST_IGNORED, 7'd2, 7'd1));
		dir_rows.push_back(fixed_row(KIND_LOOKUP, 8'd128, 32'h0,
			6'd0, 32'h0, 1'b0, ST_IGNORED, 7'd2, 7'd1));
		// Replace an occupant: count stays
		dir_rows.push_back(fixed_row(KIND_ADD_AT, 8'd0, 32'h1234_5678,
			6'd0, 32'h0, 1'b0, ST_OK, 7'd2, 7'd1));
		dir_rows.push_back(open_row(KIND_LOOKUP, 8'd0, 32'h0));
		dir_rows.push_back(open_row(KIND_ADD_LOWEST, 8'd255, 32'hFFFF_FFFF));
		dir_rows.push_back(open_row(KIND_REMOVE, 8'd0, 32'h0));
		// Lookup of an empty slot that has held a handle
		dir_rows.push_back(open_row(KIND_LOOKUP, 8'd0, 32'h0));
		dir_rows.push_back(open_row(KIND_ADD_LOWEST, 8'd17, 32'hDEAD_BEEF));
		dir_rows.push_back(fixed_row(3'd5, 8'd0, 32'h0,
			6'd0, 32'h0, 1'b0, ST_IGNORED, 7'd3, 7'd2));
		dir_rows.push_back(fixed_row(3'd7, 8'd255, 32'hFFFF_FFFF,
			6'd0, 32'h0, 1'b0, ST_IGNORED, 7'd3, 7'd2));
		dir_rows.push_back(open_row(3'd6, 8'd42, 32'h0F0F_0F0F));
		dir_rows.push_back(fixed_row(KIND_CLEAR, 8'd63, 32'h0,
			6'd0, 32'h0, 1'b0, ST_OK, 7'd0, 7'd0));
		dir_rows.push_back(fixed_row(KIND_LOOKUP, 8'd63, 32'h0,
			6'd63, 32'h0, 1'b0, ST_OK, 7'd0, 7'd0));
		foreach (dir_rows[i]) issue(dir_rows[i].op, dir_rows[i].fixed, dir_rows[i].want);

		wait_drained();

		// Fill the whole table and run past full
		repeat (SLOTS + 6) issue('{kind: KIND_ADD_LOWEST, slot_index: 8'($urandom_range(0, 255)),
			entry_data: draw_handle()}, 1'b0, '0);

		// Random bursts, some with no idling, some followed by a drain
		sent = 0;
		while (sent < 830) begin
			mode   = burst_t'($urandom_range(0, 2));
			steady = ($urandom_range(0, 3) == 0);
			len    = $urandom_range(30, 60);
			repeat (len) issue(pick_op(mode), 1'b0, '0);
			sent += len;
			if ($urandom_range(0, 2) == 0) wait_drained();
		end
		steady = 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_lowest_free_slot_table: done, clean");
		end else begin
			$display("tb_lowest_free_slot_table: done, errors");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("tb_lowest_free_slot_table: done, errors");
		$finish;
	end

endmodule

>>> filelist.f
rtl/lfst_pkg.sv
rtl/lfst_ram.sv
rtl/lfst_vac_scan.sv
rtl/lowest_free_slot_table.sv
tb/sv/tb_lowest_free_slot_table.sv
